// ===== rtl/nwh_pkg.sv =====
`timescale 1ns / 1ps

package nwh_pkg;

	// Field widths
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 19;
	localparam int CFG_W    = 3;

	// Configuration port
	localparam int APB_AW = 2;
	localparam int APB_DW = 32;

	// Lower transform length limit and reset value of log2_length
	localparam int MIN_LOG2   = 2;
	localparam int LOG2_RESET = 6;

	// Scaling constants in Q15
	localparam int          Q_FRAC        = 15;
	localparam logic [15:0] INV_SQRT2_Q15 = 16'd23170;
	localparam logic [15:0] ONE_Q15       = 16'd32768;

	// Saturation bounds of a coefficient
	localparam int COEF_MAX = (1 << (COEF_W - 1)) - 1;
	localparam int COEF_MIN = -(1 << (COEF_W - 1));

endpackage

// ===== rtl/nwh_bank.sv =====
`timescale 1ns / 1ps

module nwh_bank #(
	parameter int AW = 5,
	parameter int DW = 22
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// The read data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/nwh_scale.sv =====
`timescale 1ns / 1ps

module nwh_scale #(
	parameter int DW = 22,
	parameter int KW = 3
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               valid_in,
	input  logic signed [DW-1:0]               x,
	input  logic                               last_in,
	input  logic [KW-1:0]                      k,
	output logic                               advance,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [nwh_pkg::COEF_W-1:0]  coefficient,
	output logic                               last
);

	import nwh_pkg::*;

	localparam int PW = DW + 17;
	localparam logic signed [PW-1:0] SAT_HI = PW'(COEF_MAX);
	localparam logic signed [PW-1:0] SAT_LO = PW'(COEF_MIN);

	logic [15:0]             mult;
	logic signed [PW-1:0]    xe;
	logic signed [PW-1:0]    me;
	logic signed [PW-1:0]    prod_s2;
	logic                    valid_s2;
	logic                    last_s2;
	logic signed [PW-1:0]    rnd;
	logic signed [PW-1:0]    rounded;
	logic signed [PW-1:0]    shifted;
	logic signed [PW-1:0]    sat;
	int                      sh;

	assign advance = !out_valid || out_ready;

	// Odd lengths take the extra factor of 1/sqrt(2).
	assign mult = k[0] ? INV_SQRT2_Q15 : ONE_Q15;
	assign xe   = PW'(x);
	assign me   = PW'($signed({1'b0, mult}));

	always_comb begin
		sh      = Q_FRAC + int'(k >> 1);
		rnd     = PW'(1) <<< (sh - 1);
		rounded = prod_s2 + rnd;
		shifted = rounded >>> sh;
		if (shifted > SAT_HI) begin
			sat = SAT_HI;
		end else if (shifted < SAT_LO) begin
			sat = SAT_LO;
		end else begin
			sat = shifted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else if (advance) begin
			valid_s2  <= valid_in;
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s2     <= xe * me;
			last_s2     <= last_in;
			coefficient <= sat[COEF_W-1:0];
			last        <= last_s2;
		end
	end

endmodule

// ===== rtl/normalized_walsh_hadamard_core.sv =====
`timescale 1ns / 1ps
// Per vector of N = 2^k samples: N samples are loaded, then k butterfly stages each run
// N/2 butterflies and an idle bubble, then N coefficients are emitted, each through the
// bank read register, the product register and the output register. The butterflies run
// one a cycle on the two store banks. Reset (arst_n low, asynchronous) empties the pipeline,
// clears the sample count and sets log2_length to 6; the store contents are not cleared.

module normalized_walsh_hadamard_core #(
	parameter int MAX_LOG2_LENGTH = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [nwh_pkg::APB_AW-1:0]          paddr,
	input  logic [nwh_pkg::APB_DW-1:0]          pwdata,
	output logic [nwh_pkg::APB_DW-1:0]          prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [nwh_pkg::SAMPLE_W-1:0] sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [nwh_pkg::COEF_W-1:0]   coefficient,
	output logic                                last
);

	import nwh_pkg::*;

	// The values grow by one bit per butterfly stage, so the store is as wide as a
	// sample plus the largest stage count. Entries are split over two banks by the
	// parity of their address: the two entries of a butterfly differ in one address
	// bit, so they always sit in opposite banks and one butterfly fits in one cycle.
	localparam int W  = SAMPLE_W + MAX_LOG2_LENGTH;
	localparam int CW = MAX_LOG2_LENGTH;
	localparam int AW = MAX_LOG2_LENGTH - 1;
	localparam int KW = $clog2(MAX_LOG2_LENGTH + 1);

	typedef enum logic [1:0] {ST_LOAD, ST_XFORM, ST_BUBBLE, ST_EMIT} state_t;

	state_t             state_q;
	logic [CFG_W-1:0]   log2_q;
	logic [KW-1:0]      k_eff;
	logic [CW:0]        n_full;
	logic [CW-1:0]      n_m1;
	logic [AW-1:0]      half_m1;
	logic [CW-1:0]      load_count_q;
	logic [KW-1:0]      stage_q;
	logic [AW-1:0]      bfly_q;
	logic [CW-1:0]      emit_idx_q;
	logic               cfg_wr;
	logic               in_acc;
	logic               advance;
	logic               issue;

	// Butterfly addressing
	logic [CW-1:0]      h;
	logic [CW-1:0]      hm;
	logic [CW-1:0]      bz;
	logic [CW-1:0]      ja;
	logic [CW-1:0]      jb;
	logic               par_a;
	logic               par_load;
	logic               par_emit;

	// Butterfly write-back stage
	logic               bf_valid_s1;
	logic [CW-1:0]      ja_s1;
	logic [CW-1:0]      jb_s1;
	logic               par_a_s1;
	logic [W-1:0]       sum_s1;
	logic [W-1:0]       diff_s1;

	// Emit read stage
	logic               emit_valid_s1;
	logic               emit_par_s1;
	logic               emit_last_s1;

	// Bank ports
	logic [1:0]         wr_en;
	logic [AW-1:0]      wr_addr [2];
	logic [W-1:0]       wr_data [2];
	logic [1:0]         rd_en;
	logic [AW-1:0]      rd_addr [2];
	logic [W-1:0]       rd_data [2];

	// ------------------------------------------------------------------
	// Configuration port. Every address selects log2_length. The user must write it only
	// while the block is idle, which is not enforced; each write discards a partial vector.
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = APB_DW'(log2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_q <= CFG_W'(LOG2_RESET);
		end else if (cfg_wr) begin
			log2_q <= pwdata[CFG_W-1:0];
		end
	end

	// Lengths below the minimum act as the minimum, those above the maximum
	// act as the maximum.
	always_comb begin
		if (int'(log2_q) < MIN_LOG2) begin
			k_eff = KW'(MIN_LOG2);
		end else if (int'(log2_q) > MAX_LOG2_LENGTH) begin
			k_eff = KW'(MAX_LOG2_LENGTH);
		end else begin
			k_eff = KW'(log2_q);
		end
	end

	assign n_full  = (CW + 1)'(1) << k_eff;
	assign n_m1    = n_full[CW-1:0] - CW'(1);
	assign half_m1 = n_m1[CW-1:1];

	// ------------------------------------------------------------------
	// Butterfly j of a stage with span h pairs entry ja, which has a zero at
	// bit log2(h), with entry jb = ja + h.
	// ------------------------------------------------------------------
	assign h     = CW'(1) << stage_q;
	assign hm    = h - CW'(1);
	assign bz    = CW'(bfly_q);
	assign ja    = ((bz & ~hm) << 1) | (bz & hm);
	assign jb    = ja | h;
	assign par_a = ^ja;

	assign par_load = ^load_count_q;
	assign par_emit = ^emit_idx_q;

	// The last sample of a vector is held off while an emit read of the previous
	// vector still waits in the read register, since the transform reuses it.
	assign in_ready = (state_q == ST_LOAD) && !((load_count_q == n_m1) && emit_valid_s1);
	assign in_acc   = in_valid && in_ready;
	assign issue    = (state_q == ST_EMIT) && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			load_count_q <= '0;
			stage_q      <= '0;
			bfly_q       <= '0;
			emit_idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (cfg_wr) begin
						load_count_q <= '0;
					end else if (in_acc) begin
						if (load_count_q == n_m1) begin
							load_count_q <= '0;
							stage_q      <= '0;
							bfly_q       <= '0;
							state_q      <= ST_XFORM;
						end else begin
							load_count_q <= load_count_q + CW'(1);
						end
					end
				end
				ST_XFORM: begin
					if (bfly_q == half_m1) begin
						bfly_q  <= '0;
						state_q <= ST_BUBBLE;
					end else begin
						bfly_q <= bfly_q + AW'(1);
					end
				end
				// The idle bubble lets the stage's last write land before the next
				// stage, or the emit pass, reads the store again.
				ST_BUBBLE: begin
					if (stage_q == k_eff - KW'(1)) begin
						emit_idx_q <= '0;
						state_q    <= ST_EMIT;
					end else begin
						stage_q <= stage_q + KW'(1);
						state_q <= ST_XFORM;
					end
				end
				ST_EMIT: begin
					if (advance) begin
						if (emit_idx_q == n_m1) begin
							state_q <= ST_LOAD;
						end else begin
							emit_idx_q <= emit_idx_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Butterfly pipeline: read both entries, then write sum and difference back.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bf_valid_s1 <= 1'b0;
		end else begin
			bf_valid_s1 <= (state_q == ST_XFORM);
		end
	end

	always_ff @(posedge clk) begin
		ja_s1    <= ja;
		jb_s1    <= jb;
		par_a_s1 <= par_a;
	end

	assign sum_s1  = rd_data[par_a_s1] + rd_data[~par_a_s1];
	assign diff_s1 = rd_data[par_a_s1] - rd_data[~par_a_s1];

	// Emit read stage; it moves only when the output side moves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_valid_s1 <= 1'b0;
		end else if (advance) begin
			emit_valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			emit_par_s1  <= par_emit;
			emit_last_s1 <= (emit_idx_q == n_m1);
		end
	end

	// ------------------------------------------------------------------
	// Bank port selection. Loading and butterfly write-back never overlap.
	// ------------------------------------------------------------------
	always_comb begin
		wr_en   = '0;
		wr_addr = '{default: '0};
		wr_data = '{default: '0};
		rd_en   = '0;
		rd_addr = '{default: '0};
		if (in_acc) begin
			wr_en[par_load]   = 1'b1;
			wr_addr[par_load] = load_count_q[CW-1:1];
			wr_data[par_load] = W'(sample);
		end
		if (bf_valid_s1) begin
			wr_en[par_a_s1]    = 1'b1;
			wr_addr[par_a_s1]  = ja_s1[CW-1:1];
			wr_data[par_a_s1]  = sum_s1;
			wr_en[~par_a_s1]   = 1'b1;
			wr_addr[~par_a_s1] = jb_s1[CW-1:1];
			wr_data[~par_a_s1] = diff_s1;
		end
		if (state_q == ST_XFORM) begin
			rd_en            = 2'b11;
			rd_addr[par_a]   = ja[CW-1:1];
			rd_addr[~par_a]  = jb[CW-1:1];
		end else if (issue) begin
			rd_en[par_emit]   = 1'b1;
			rd_addr[par_emit] = emit_idx_q[CW-1:1];
		end
	end

	for (genvar b = 0; b < 2; b++) begin : g_bank
		nwh_bank #(
			.AW (AW),
			.DW (W)
		) u_bank (
			.clk     (clk),
			.wr_en   (wr_en[b]),
			.wr_addr (wr_addr[b]),
			.wr_data (wr_data[b]),
			.rd_en   (rd_en[b]),
			.rd_addr (rd_addr[b]),
			.rd_data (rd_data[b])
		);
	end

	// ------------------------------------------------------------------
	// Normalisation and the output register. Each transaction on the output
	// carries one coefficient, with last set on the final one of the vector.
	// ------------------------------------------------------------------
	nwh_scale #(
		.DW (W),
		.KW (KW)
	) u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_in    (emit_valid_s1),
		.x           ($signed(rd_data[emit_par_s1])),
		.last_in     (emit_last_s1),
		.k           (k_eff),
		.advance     (advance),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.coefficient (coefficient),
		.last        (last)
	);

endmodule

// ===== rtl/nwh_checker.sv =====
`timescale 1ns / 1ps

module nwh_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                psel,
	input logic                                penable,
	input logic                                pwrite,
	input logic [nwh_pkg::APB_DW-1:0]          pwdata,
	input logic [nwh_pkg::APB_DW-1:0]          prdata,
	input logic                                pready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [nwh_pkg::COEF_W-1:0]   coefficient,
	input logic                                last
);

	import nwh_pkg::*;

	// The configuration port never inserts wait states.
	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	// A completed register write is read back in the following cycle.
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite |=> prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]))
		else $error("log2_length does not read back the written value");

	// A stalled coefficient is held unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(coefficient) && $stable(last))
		else $error("output transaction changed while stalled");

	// After the final coefficient of a vector, the next vector cannot follow at once.
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> !out_valid)
		else $error("coefficient directly after the last of a vector");

endmodule

bind normalized_walsh_hadamard_core nwh_checker u_nwh_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import nwh_pkg::*;

	localparam int MAX_LOG2        = 6;
	localparam int REG_LOG2_LENGTH = 0;
	localparam int RANDOM_ITEMS    = 300;
	// Cycles allowed after the last coefficient before the block counts as idle.
	localparam int SETTLE_CYCLES   = 16;
	localparam int DRAIN_LIMIT     = 20000;

	typedef enum logic [1:0] {OP_SAMPLE, OP_WRITE, OP_READ} step_op_t;

	// One row of the directed table. For a sample row, pin asks that the first
	// coefficient of the vector it completes is the typed-in value in pinned. For a
	// read row, value holds the register contents that the read must return.
	typedef struct packed {
		step_op_t           op;
		logic signed [31:0] value;
		logic               pin;
		logic signed [31:0] pinned;
	} step_t;

	typedef struct {
		logic signed [COEF_W-1:0] coefficient;
		logic                     last;
	} coef_t;

	// The directed part. The 4-point vectors first check rounding, where a tie must
	// go upward. Then come the widest sums of both signs. A partial 8-point vector
	// is then thrown away by a register write. A read-back and an ordinary 8-point
	// vector follow, and last of all the register is set above its range.
	localparam step_t DIRECTED [36] = '{
		'{OP_READ,   32'sd6,      1'b0, 32'sd0},
		'{OP_WRITE,  32'sd0,      1'b0, 32'sd0},
		'{OP_SAMPLE, 32'sd1,      1'b0, 32'sd0},
		'{OP_SAMPLE, 32'sd0,      1'b0, 32'sd0},
		'{OP_SAMPLE, 32'sd0,      1'b0, 32'sd0},
		'{OP_SAMPLE, 32'sd0,      1'b1, 32'sd1},
		'{OP_WRITE,  32'sd1,      1'b0, 32'sd0},
		'{OP_SAMPLE, -32'sd1,     1'b0, 32'sd0},
		'{OP_SAMPLE, 32'sd0,      1'b0, 32'sd0},
		'{OP_SAMPLE, 32'sd0,      1'b0, 32'sd0},
		'{OP_SAMPLE, 32'sd0,      1'b1, 32'sd0},
		'{OP_WRITE,  32'sd2,      1'b0, 32'sd0},
		'{OP_SAMPLE, -32'sd32768, 1'b0, 32'sd0},
		'{OP_SAMPLE, -32'sd32768, 1'b0, 32'sd0},
		'{OP_SAMPLE, -32'sd32768, 1'b0, 32'sd0},
		'{OP_SAMPLE, -32'sd32768, 1'b1, -32'sd65536},
		'{OP_SAMPLE, 32'sd32767,  1'b0, 32'sd0},
		'{OP_SAMPLE, 32'sd32767,  1'b0, 32'sd0},
		'{OP_SAMPLE, 32'sd32767,  1'b0, 32'sd0},
		'{OP_SAMPLE, 32'sd32767,  1'b1, 32'sd65534},
		'{OP_WRITE,  32'sd3,      1'b0, 32'sd0},
		'{OP_SAMPLE, 32'sd32767,  1'b0, 32'sd0},
		'{OP_SAMPLE, -32'sd32768, 1'b0, 32'sd0},
		'{OP_SAMPLE, 32'sd5,      1'b0, 32'sd0},
		'{OP_WRITE,  32'sd3,      1'b0, 32'sd0},
		'{OP_READ,   32'sd3,      1'b0, 32'sd0},
		'{OP_SAMPLE, 32'sd32767,  1'b0, 32'sd0},
		'{OP_SAMPLE, -32'sd32768, 1'b0, 32'sd0},
		'{OP_SAMPLE, 32'sd0,      1'b0, 32'sd0},
		'{OP_SAMPLE, -32'sd1,     1'b0, 32'sd0},
		'{OP_SAMPLE, 32'sd1,      1'b0, 32'sd0},
		'{OP_SAMPLE, 32'sd12345,  1'b0, 32'sd0},
		'{OP_SAMPLE, -32'sd12345, 1'b0, 32'sd0},
		'{OP_SAMPLE, 32'sd21845,  1'b0, 32'sd0},
		'{OP_WRITE,  32'sd7,      1'b0, 32'sd0},
		'{OP_READ,   32'sd7,      1'b0, 32'sd0}
	};

	// The first random phases try register values above and below the length range and
	// both parities of the length before the choice becomes random.
	localparam logic [CFG_W-1:0] OPENING_LOG2 [4] = '{3'd7, 3'd6, 3'd1, 3'd5};

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       psel      = 1'b0;
	logic                       penable   = 1'b0;
	logic                       pwrite    = 1'b0;
	logic [APB_AW-1:0]          paddr     = '0;
	logic [APB_DW-1:0]          pwdata    = '0;
	logic [APB_DW-1:0]          prdata;
	logic                       pready;
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample    = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [COEF_W-1:0]   coefficient;
	logic                       last;

	// Our own copy of the block's state: the register, the samples gathered so far
	// and the coefficients still to come out, oldest first.
	logic [CFG_W-1:0] held_log2 = CFG_W'(LOG2_RESET);
	int               samples_held = 0;
	int               work_vec [1 << MAX_LOG2];
	coef_t            pending_coefs [$];

	int fault_count = 0;
	int stall_left  = 0;
	bit steady      = 1'b0;  // when set, neither side idles

	normalized_walsh_hadamard_core #(
		.MAX_LOG2_LENGTH(MAX_LOG2)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.coefficient(coefficient),
		.last       (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic flag_fault(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fault_count++;
	endtask

	// Gap lengths for both sides: mostly none or short, now and then a long one.
	function automatic int idle_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	// The result to expect for one transform value x at length 2^k. The butterfly
	// sum is scaled by 1/sqrt(2^k): for even k a plain shift, for odd k a multiply
	// by 1/sqrt(2) in Q15 as well. Adding half an LSB before an arithmetic shift
	// floors towards minus infinity, which makes a tie round upward. Results
	// outside the 19-bit range saturate.
	function automatic logic signed [COEF_W-1:0] scale_coef(input int x, input int k);
		longint gain;
		longint prod;
		longint q;
		int     sh;
		gain = (k % 2) ? longint'(INV_SQRT2_Q15) : longint'(ONE_Q15);
		sh   = Q_FRAC + k / 2;
		prod = longint'(x) * gain + (longint'(1) << (sh - 1));
		q    = prod >>> sh;
		if (q > COEF_MAX)
			q = COEF_MAX;
		if (q < COEF_MIN)
			q = COEF_MIN;
		return q[COEF_W-1:0];
	endfunction

	// Takes one accepted sample into the predicted state. When the vector is
	// complete, the butterfly stages are run in place, with the span doubling from
	// 1. The scaled coefficients then join the queue in index order.
	function automatic void absorb_sample(input logic signed [SAMPLE_W-1:0] value,
	                                      input bit pin, input int pinned);
		int    k;
		int    n;
		int    a;
		int    b;
		coef_t c;
		k = held_log2;
		if (k < MIN_LOG2)
			k = MIN_LOG2;
		if (k > MAX_LOG2)
			k = MAX_LOG2;
		n = 1 << k;
		if (samples_held >= n)
			samples_held = 0;
		work_vec[samples_held] = value;
		samples_held++;
		if (samples_held < n)
			return;
		for (int h = 1; h < n; h = h << 1) begin
			for (int i = 0; i < n; i += 2 * h) begin
				for (int j = i; j < i + h; j++) begin
					a               = work_vec[j];
					b               = work_vec[j + h];
					work_vec[j]     = a + b;
					work_vec[j + h] = a - b;
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			c.coefficient = scale_coef(work_vec[i], k);
			c.last        = (i == n - 1);
			if (i == 0 && pin)
				c.coefficient = pinned[COEF_W-1:0];
			pending_coefs.push_back(c);
		end
		samples_held = 0;
	endfunction

	// Offers one sample after a random gap and waits for the transaction. The valid
	// is only lowered when a gap is wanted, so back-to-back samples keep it high.
	task automatic push_sample(input logic signed [SAMPLE_W-1:0] value,
	                           input bit pin, input int pinned);
		int gap;
		gap = steady ? 0 : idle_length();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= value;
		do @(posedge clk); while (!in_ready);
		absorb_sample(value, pin, pinned);
	endtask

	// A sample drawn to hit the extremes, small values about zero and the full range.
	function automatic logic signed [SAMPLE_W-1:0] draw_sample();
		case ($urandom_range(0, 7))
			0:       return -16'sd32768;
			1:       return 16'sd32767;
			2:       return SAMPLE_W'($signed($urandom_range(0, 16)) - 8);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// Each APB task ends with the bus left idle, so that the next transfer never
	// drives psel or penable twice within one time step.
	task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read(input logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// pready is always high, so this edge ends the access phase.
		data     = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every expected coefficient has come out, then for SETTLE_CYCLES more,
	// so that the block is idle before its register is touched.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_coefs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes log2_length and reads it back. A write also drops any part-loaded
	// vector, both in the block and in our copy of its state.
	task automatic set_log2(input logic [CFG_W-1:0] value);
		logic [APB_DW-1:0] readback;
		settle();
		apb_write(APB_AW'(REG_LOG2_LENGTH * 4), APB_DW'(value));
		held_log2    = value;
		samples_held = 0;
		apb_read(APB_AW'(REG_LOG2_LENGTH * 4), readback);
		if (readback[CFG_W-1:0] !== value)
			flag_fault($sformatf("log2_length reads %0d after writing %0d",
			                     readback[CFG_W-1:0], value));
	endtask

	// Result side: every coefficient transaction is compared with the oldest
	// expectation. The ready stalls are drawn here as well.
	always @(posedge clk) begin : coef_monitor
		coef_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_coefs.size() == 0) begin
				flag_fault($sformatf("coefficient %0d arrived with none expected",
				                     coefficient));
			end else begin
				want = pending_coefs.pop_front();
				if (coefficient !== want.coefficient)
					flag_fault($sformatf("coefficient is %0d, expected %0d",
					                     coefficient, want.coefficient));
				if (last !== want.last)
					flag_fault($sformatf("last is %b, expected %b", last, want.last));
			end
		end
		if (steady || stall_left == 0) begin
			out_ready <= 1'b1;
			if (!steady)
				stall_left = idle_length();
		end else begin
			out_ready <= 1'b0;
			stall_left--;
		end
	end

	// Stimulus: reset, the directed table, then random phases, each with its own
	// length setting and some with a part-loaded vector left for the next write.
	initial begin : stimulus
		logic [APB_DW-1:0] readback;
		logic [CFG_W-1:0]  next_log2;
		int                sent;
		int                phase;
		int                k_eff;
		int                n;
		int                vectors;
		int                waited;
		sent  = 0;
		phase = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[r]) begin
			case (DIRECTED[r].op)
				OP_SAMPLE: begin
					push_sample(DIRECTED[r].value[SAMPLE_W-1:0], DIRECTED[r].pin,
					            DIRECTED[r].pinned);
				end
				OP_WRITE: begin
					set_log2(DIRECTED[r].value[CFG_W-1:0]);
				end
				OP_READ: begin
					settle();
					apb_read(APB_AW'(REG_LOG2_LENGTH * 4), readback);
					if (readback[CFG_W-1:0] !== DIRECTED[r].value[CFG_W-1:0])
						flag_fault($sformatf("log2_length reads %0d, expected %0d",
						                     readback[CFG_W-1:0],
						                     DIRECTED[r].value[CFG_W-1:0]));
				end
				default: begin
				end
			endcase
		end

		while (sent < RANDOM_ITEMS) begin
			if (phase < 4)
				next_log2 = OPENING_LOG2[phase];
			else
				next_log2 = CFG_W'($urandom_range(0, 7));
			set_log2(next_log2);
			// About one phase in five runs with neither side idling.
			steady = ($urandom_range(0, 4) == 0);
			k_eff  = next_log2;
			if (k_eff < MIN_LOG2)
				k_eff = MIN_LOG2;
			if (k_eff > MAX_LOG2)
				k_eff = MAX_LOG2;
			n = 1 << k_eff;
			// Long vectors are slow, so they come one to a phase.
			vectors = (k_eff >= 5) ? 1 : $urandom_range(1, 4);
			repeat (vectors) begin
				repeat (n) push_sample(draw_sample(), 1'b0, 0);
				sent += n;
			end
			// Now and then a vector is left part-loaded, for the next write to discard.
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, n - 1)) begin
					push_sample(draw_sample(), 1'b0, 0);
					sent++;
				end
			end
			steady = 1'b0;
			phase++;
		end
		in_valid <= 1'b0;

		waited = 0;
		while (pending_coefs.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_coefs.size() != 0)
			flag_fault($sformatf("%0d coefficients never arrived", pending_coefs.size()));

		if (fault_count == 0) begin
			$display("normalized_walsh_hadamard_core regression: pass");
		end else begin
			$display("normalized_walsh_hadamard_core regression: fail");
		end
		$finish;
	end

	// Safety net: a correct run takes well under a tenth of this time, even with
	// every vector at full length and the longest stalls on both sides.
	initial begin : watchdog
		#10_000_000;
		$display("normalized_walsh_hadamard_core regression: fail");
		$finish;
	end

endmodule
